// File: sv/ils_pkg.sv
// ils_pkg: shared types, opcodes and status codes for the indexed list store
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ils_pkg;

   localparam int CAPACITY_DEFAULT = 16;

   localparam int OPCODE_W = 3;
   localparam int POS_W    = 5;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [OPCODE_W-1:0] OP_PUSH   = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_POP    = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_GET    = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_SET    = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd6;

   localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_BOUNDS = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd2;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
   } ctrl_cmd_type;

endpackage

`default_nettype wire

// File: sv/ils_ctrl.sv
// ils_ctrl: controller state machine, sequences capture and execution of a command
// depends on ils_pkg
`timescale 1ns / 1ps
`default_nettype none

module ils_ctrl
   import ils_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output ctrl_cmd_type      cmd,
   output logic              busy,
   output logic              rsp_valid
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd          = '0;
      busy         = 1'b0;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load = start;
         end
         S_EXEC: begin
            cmd.exec     = 1'b1;
            busy         = 1'b1;
            rsp_valid_in = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && cmd.exec))
      else $error("accepted command did not execute");

   a_exec_strobes: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_valid)
      else $error("execution without result strobe");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && !cmd.exec))
      else $error("result strobe while executing");

   a_strobe_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held over two cycles");

endmodule

`default_nettype wire

// File: sv/ils_datapath.sv
// ils_datapath: shifting entry cells, fill counter and result registers
// depends on ils_pkg
`timescale 1ns / 1ps
`default_nettype none

module ils_datapath
   import ils_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire ctrl_cmd_type                cmd,
   input  wire logic [OPCODE_W-1:0]         req_opcode,
   input  wire logic [POS_W-1:0]            req_position,
   input  wire logic signed [WORD_W-1:0]    req_value,
   output logic [STATUS_W-1:0]              rsp_status,
   output logic signed [WORD_W-1:0]         rsp_read_value,
   output logic [COUNT_W-1:0]               rsp_count
);

   localparam int FILL_W = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (FILL_W > POS_W) ? FILL_W : POS_W;

   logic [OPCODE_W-1:0]      op_ff;
   logic [POS_W-1:0]         pos_ff;
   logic signed [WORD_W-1:0] val_ff;

   logic signed [WORD_W-1:0] cell_ff [CAPACITY];
   logic signed [WORD_W-1:0] cell_in [CAPACITY];
   logic [FILL_W-1:0]        fill_ff, fill_in;

   logic [STATUS_W-1:0]      status_ff, status_in;
   logic signed [WORD_W-1:0] rd_ff, rd_in;

   logic [CMP_W-1:0]         pos_x, fill_x, rd_sel;
   logic                     full;
   logic                     do_push, do_pop, do_set, do_ins, do_rem, do_clr;
   logic signed [WORD_W-1:0] rd_word;

   assign pos_x  = CMP_W'(pos_ff);
   assign fill_x = CMP_W'(fill_ff);
   assign full   = (fill_ff >= FILL_W'(CAPACITY));

   // read selection
   always_comb begin
      rd_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (rd_sel == CMP_W'(i)) begin
            rd_word = cell_ff[i];
         end
      end
   end

   always_comb begin
      status_in = STAT_OK;
      rd_in     = '0;
      rd_sel    = pos_x;
      do_push   = 1'b0;
      do_pop    = 1'b0;
      do_set    = 1'b0;
      do_ins    = 1'b0;
      do_rem    = 1'b0;
      do_clr    = 1'b0;
      unique case (op_ff)
         OP_PUSH: begin
            if (full) begin
               status_in = STAT_FULL;
            end else begin
               do_push = 1'b1;
            end
         end
         OP_POP: begin
            rd_sel = fill_x - CMP_W'(1);
            if (fill_ff == '0) begin
               status_in = STAT_BOUNDS;
            end else begin
               do_pop = 1'b1;
               rd_in  = rd_word;
            end
         end
         OP_GET: begin
            if (pos_x >= fill_x) begin
               status_in = STAT_BOUNDS;
            end else begin
               rd_in = rd_word;
            end
         end
         OP_SET: begin
            if (pos_x >= fill_x) begin
               status_in = STAT_BOUNDS;
            end else begin
               do_set = 1'b1;
            end
         end
         OP_INSERT: begin
            if (pos_x > fill_x) begin
               status_in = STAT_BOUNDS;
            end else if (full) begin
               status_in = STAT_FULL;
            end else begin
               do_ins = 1'b1;
            end
         end
         OP_REMOVE: begin
            if (pos_x >= fill_x) begin
               status_in = STAT_BOUNDS;
            end else begin
               do_rem = 1'b1;
            end
         end
         OP_CLEAR: begin
            do_clr = 1'b1;
         end
         default: begin
            status_in = STAT_OK;
         end
      endcase
   end

   always_comb begin
      fill_in = fill_ff;
      if (do_push || do_ins) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (do_pop || do_rem) begin
         fill_in = fill_ff - FILL_W'(1);
      end else if (do_clr) begin
         fill_in = '0;
      end
   end

   // per-cell next value: write, shift up from below, shift down from above
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [CMP_W-1:0]         idx;
      logic signed [WORD_W-1:0] below, above;
      assign idx = CMP_W'(g);
      if (g > 0) begin : g_below
         assign below = cell_ff[g-1];
      end else begin : g_no_below
         assign below = cell_ff[g];
      end
      if (g < CAPACITY - 1) begin : g_above
         assign above = cell_ff[g+1];
      end else begin : g_no_above
         assign above = cell_ff[g];
      end
      always_comb begin
         cell_in[g] = cell_ff[g];
         if (do_push && (idx == fill_x)) begin
            cell_in[g] = val_ff;
         end else if ((do_set || do_ins) && (idx == pos_x)) begin
            cell_in[g] = val_ff;
         end else if (do_ins && (idx > pos_x)) begin
            cell_in[g] = below;
         end else if (do_rem && (idx >= pos_x)) begin
            cell_in[g] = above;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_opcode;
         pos_ff <= req_position;
         val_ff <= req_value;
      end
      if (cmd.exec) begin
         for (int i = 0; i < CAPACITY; i++) begin
            cell_ff[i] <= cell_in[i];
         end
         status_ff <= status_in;
         rd_ff     <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (cmd.exec) begin
         fill_ff <= fill_in;
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_read_value = rd_ff;
   assign rsp_count      = COUNT_W'(fill_ff);

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(CAPACITY))
      else $error("fill beyond capacity");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && !do_clr && !do_push && !do_ins && !do_pop && !do_rem) |=>
      $stable(fill_ff))
      else $error("fill changed on a command that keeps it");

   a_rd_zero: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && status_in != STAT_OK) |=> (rd_ff == '0))
      else $error("read word on a rejected command");

endmodule

`default_nettype wire

// File: sv/indexed_list_store.sv
// indexed_list_store: top level, joins the controller and the datapath
// depends on ils_pkg, ils_ctrl, ils_datapath
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit words with push, pop, get, set,
// insert, remove and clear. A command is taken when start is high and busy is
// low; busy then stays high for one cycle while the shifting cells, the fill
// counter and the result registers update, and in the cycle after that the
// result shows for exactly one cycle with rsp_valid high. A new command can be
// taken in that same cycle, so each command passes through the capture step and
// the execute step of the controller. The receiver cannot stall: a result must
// be taken in its strobe cycle. Entries above the fill count are never read, so
// the cells need no clearing after reset.
module indexed_list_store
   import ils_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [OPCODE_W-1:0]         req_opcode,
   input  wire logic [POS_W-1:0]            req_position,
   input  wire logic signed [WORD_W-1:0]    req_value,
   output logic                             rsp_valid,
   output logic [STATUS_W-1:0]              rsp_status,
   output logic signed [WORD_W-1:0]         rsp_read_value,
   output logic [COUNT_W-1:0]               rsp_count
);

   ctrl_cmd_type cmd;

   ils_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   ils_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_opcode     (req_opcode),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count)
   );

endmodule

`default_nettype wire
